// File: design/bsa_pkg.sv
package bsa_pkg;

	// default sizes
	localparam int MAX_EQN_DEF        = 4096;
	localparam int MAX_BLOCKS_DEF     = 16384;
	localparam int MAX_BLOCK_EDGE_DEF = 4;
	localparam int QUEUE_DEPTH        = 4;

	// request codes
	localparam logic [2:0] REQ_LOAD_ROW = 3'd0;
	localparam logic [2:0] REQ_LOAD_COL = 3'd1;
	localparam logic [2:0] REQ_ADD      = 3'd2;
	localparam logic [2:0] REQ_READ     = 3'd3;
	localparam logic [2:0] REQ_CLEAR    = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_RANGE     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// configuration register indexes
	localparam logic CFG_BLOCK_SIZE = 1'b0;
	localparam logic CFG_NUM_EQN    = 1'b1;

	// effective configuration
	typedef struct packed {
		logic [3:0]  bs;
		logic [6:0]  bs2;
		logic [12:0] neq;
	} bsa_cfg_t;

	// classified request between front and back
	typedef struct packed {
		logic [2:0]         kind;
		logic [17:0]        addr;
		logic [14:0]        word;
		logic [11:0]        brow;
		logic [11:0]        bcol;
		logic [2:0]         roff;
		logic [2:0]         coff;
		logic               idx_err;
		logic signed [63:0] value;
	} bsa_op_t;

	// ceil(2^16 / b): exact quotient for 12-bit dividends
	function automatic logic [16:0] recip(input logic [3:0] b);
		logic [16:0] m;
		unique case (b)
			4'd2:    m = 17'd32768;
			4'd3:    m = 17'd21846;
			4'd4:    m = 17'd16384;
			4'd5:    m = 17'd13108;
			4'd6:    m = 17'd10923;
			4'd7:    m = 17'd9363;
			4'd8:    m = 17'd8192;
			default: m = 17'd65536;
		endcase
		return m;
	endfunction

endpackage

// File: design/bsa_if.sv
interface bsa_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic [17:0]        addr;
	logic [14:0]        load_word;
	logic [11:0]        row;
	logic [11:0]        col;
	logic signed [63:0] value;

	modport source (output valid, req_type, addr, load_word, row, col, value, input ready);
	modport sink (input valid, req_type, addr, load_word, row, col, value, output ready);
endinterface

interface bsa_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [63:0] read_value;

	modport source (output valid, status, read_value, input ready);
	modport sink (input valid, status, read_value, output ready);
endinterface

// File: design/block_sparse_accumulate.sv
// block_sparse_accumulate: block CSR store with saturating Q32.32 accumulate
// steps: a load or an unknown request goes from idle straight to the result; an in-range read
// waits on the value store; an add that passes its checks fetches the row pointers, scans the
// block columns, forms the index, then reads and writes the value; a clear zeroes every value word
// sequencing: one request at a time in the sequencer; a result waits until the output is free
// reset: async active low; then the value store is zeroed before any request is carried out
module block_sparse_accumulate #(
	parameter int MAX_EQN        = bsa_pkg::MAX_EQN_DEF,
	parameter int MAX_BLOCKS     = bsa_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_BLOCK_EDGE = bsa_pkg::MAX_BLOCK_EDGE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [12:0] cfg_wdata,
	bsa_req_if.sink     req_ch,
	bsa_res_if.source   res_ch
);
	import bsa_pkg::*;

	bsa_cfg_t   cfg_q;
	logic [3:0] bs_new;
	logic       push_valid, push_ready, pop_valid, pop_ready;
	bsa_op_t    push_data, pop_data;

	// block size clamp
	always_comb begin
		bs_new = {1'b0, cfg_wdata[2:0]};
		if (cfg_wdata[2:0] == 3'd0) begin
			bs_new = 4'd1;
		end else if (32'(cfg_wdata[2:0]) > MAX_BLOCK_EDGE) begin
			bs_new = 4'(MAX_BLOCK_EDGE);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bs  <= 4'd1;
			cfg_q.bs2 <= 7'd1;
			cfg_q.neq <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_BLOCK_SIZE: begin
					cfg_q.bs  <= bs_new;
					cfg_q.bs2 <= 7'(bs_new) * 7'(bs_new);
				end
				CFG_NUM_EQN: begin
					cfg_q.neq <= (32'(cfg_wdata) > MAX_EQN) ? 13'(MAX_EQN) : cfg_wdata;
				end
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	bsa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req_ch     (req_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bsa_back #(
		.MAX_EQN        (MAX_EQN),
		.MAX_BLOCKS     (MAX_BLOCKS),
		.MAX_BLOCK_EDGE (MAX_BLOCK_EDGE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res_ch    (res_ch)
	);

	// error results never carry a value word
	a_err_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.status != ST_OK |-> res_ch.read_value == 64'sd0)
		else $error("error result with nonzero value");

	// clamped block size lies in 1..MAX_BLOCK_EDGE and its square agrees
	a_bs_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_q.bs != 4'd0 && 32'(cfg_q.bs) <= MAX_BLOCK_EDGE &&
		cfg_q.bs2 == 7'(cfg_q.bs) * 7'(cfg_q.bs))
		else $error("block size out of range");

	// status code never beyond block not found
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> res_ch.status == ST_OK || res_ch.status == ST_RANGE ||
		res_ch.status == ST_NOT_FOUND)
		else $error("bad status code");
endmodule

// File: design/bsa_front.sv
module bsa_front (
	input  logic              clk,
	input  logic              arst_n,
	input  bsa_pkg::bsa_cfg_t cfg,
	bsa_req_if.sink           req_ch,
	output logic              push_valid,
	input  logic              push_ready,
	output bsa_pkg::bsa_op_t  push_data
);
	import bsa_pkg::*;

	logic              v_s1, v_s2;
	bsa_op_t           op_s1, op_s2;
	logic [11:0]       row_s2, col_s2;
	logic [11:0]       row_s1, col_s1;
	logic [28:0]       rprod, cprod;
	logic              adv1, adv2;
	logic [15:0]       rback, cback;

	assign adv2 = v_s2 && push_ready;
	assign adv1 = !v_s2 || adv2;
	assign req_ch.ready = !v_s1 || adv1;

	// quotient by reciprocal multiply
	assign rprod = 29'(row_s1) * 29'(recip(cfg.bs));
	assign cprod = 29'(col_s1) * 29'(recip(cfg.bs));

	// stage 1: capture and range check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_ch.ready) begin
			v_s1 <= req_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.ready && req_ch.valid) begin
			op_s1.kind    <= req_ch.req_type;
			op_s1.addr    <= req_ch.addr;
			op_s1.word    <= req_ch.load_word;
			op_s1.brow    <= '0;
			op_s1.bcol    <= '0;
			op_s1.roff    <= '0;
			op_s1.coff    <= '0;
			op_s1.idx_err <= ({1'b0, req_ch.row} >= cfg.neq) ||
				({1'b0, req_ch.col} >= cfg.neq);
			op_s1.value   <= req_ch.value;
			row_s1        <= req_ch.row;
			col_s1        <= req_ch.col;
		end
	end

	// stage 2: block row and column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && v_s1) begin
			op_s2      <= op_s1;
			op_s2.brow <= rprod[27:16];
			op_s2.bcol <= cprod[27:16];
			row_s2     <= row_s1;
			col_s2     <= col_s1;
		end
	end

	// offsets inside the block
	assign rback = 16'(op_s2.brow) * 16'(cfg.bs);
	assign cback = 16'(op_s2.bcol) * 16'(cfg.bs);

	always_comb begin
		push_data      = op_s2;
		push_data.roff = 3'(16'(row_s2) - rback);
		push_data.coff = 3'(16'(col_s2) - cback);
	end

	assign push_valid = v_s2;
endmodule

// File: design/bsa_queue.sv
module bsa_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  bsa_pkg::bsa_op_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output bsa_pkg::bsa_op_t pop_data
);
	import bsa_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);

	bsa_op_t        mem_q [QUEUE_DEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic           do_push, do_pop;

	assign push_ready = cnt_q != (QAW+1)'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rp_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_data;
		end
	end
endmodule

// File: design/bsa_back.sv
module bsa_back #(
	parameter int MAX_EQN        = bsa_pkg::MAX_EQN_DEF,
	parameter int MAX_BLOCKS     = bsa_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_BLOCK_EDGE = bsa_pkg::MAX_BLOCK_EDGE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bsa_pkg::bsa_cfg_t cfg,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  bsa_pkg::bsa_op_t  pop_data,
	bsa_res_if.source         res_ch
);
	import bsa_pkg::*;

	localparam int RS_DEPTH  = MAX_EQN + 1;
	localparam int RS_AW     = $clog2(RS_DEPTH);
	localparam int BC_AW     = $clog2(MAX_BLOCKS);
	localparam int VAL_DEPTH = MAX_BLOCKS * MAX_BLOCK_EDGE * MAX_BLOCK_EDGE;
	localparam int VAL_AW    = $clog2(VAL_DEPTH);
	localparam int KW        = (BC_AW + 1 > 15) ? BC_AW + 1 : 15;

	typedef enum logic [9:0] {
		S_CLR  = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_PTR  = 10'b0000000100,
		S_SCAN = 10'b0000001000,
		S_CHK  = 10'b0000010000,
		S_IDX  = 10'b0000100000,
		S_VRD  = 10'b0001000000,
		S_VWR  = 10'b0010000000,
		S_RDW  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	state_t              state_q;
	bsa_op_t             cur_q;
	logic [KW-1:0]       k_q, end_q;
	logic [1:0]          st_q;
	logic signed [63:0]  rd_q;
	logic [VAL_AW-1:0]   clr_q, idx_q;
	logic                clr_req_q;
	logic                out_v_q;
	logic [1:0]          out_st_q;
	logic signed [63:0]  out_rd_q;

	logic [14:0]         rs_mem [RS_DEPTH];
	logic [11:0]         bc_mem [MAX_BLOCKS];
	logic [63:0]         val_mem [VAL_DEPTH];
	logic [14:0]         rs_a_q, rs_b_q;
	logic [11:0]         bc_rd_q;
	logic [63:0]         vd_q;

	logic                take, out_free;
	logic                rs_we, bc_we, val_we;
	logic [VAL_AW-1:0]   val_waddr, val_raddr;
	logic [63:0]         val_wdata, sum;

	assign pop_ready = state_q == S_IDLE;
	assign take      = pop_valid && pop_ready;
	assign out_free  = !out_v_q || res_ch.ready;

	// saturating Q32.32 add, or zero while clearing
	assign sum = vd_q + cur_q.value;
	always_comb begin
		val_wdata = sum;
		if (vd_q[63] == cur_q.value[63] && sum[63] != vd_q[63]) begin
			val_wdata = vd_q[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end
		if (state_q == S_CLR) begin
			val_wdata = '0;
		end
	end

	// store write and read ports
	assign rs_we = take && pop_data.kind == REQ_LOAD_ROW && 32'(pop_data.addr) < RS_DEPTH;
	assign bc_we = take && pop_data.kind == REQ_LOAD_COL && 32'(pop_data.addr) < MAX_BLOCKS;
	assign val_we    = (state_q == S_CLR) || (state_q == S_VWR);
	assign val_waddr = (state_q == S_CLR) ? clr_q : idx_q;
	assign val_raddr = (state_q == S_IDLE) ? VAL_AW'(pop_data.addr) : idx_q;

	always_ff @(posedge clk) begin
		if (rs_we) begin
			rs_mem[RS_AW'(pop_data.addr)] <= pop_data.word;
		end
		rs_a_q <= rs_mem[RS_AW'(pop_data.brow)];
		rs_b_q <= rs_mem[RS_AW'(13'(pop_data.brow) + 13'd1)];
	end

	always_ff @(posedge clk) begin
		if (bc_we) begin
			bc_mem[BC_AW'(pop_data.addr)] <= pop_data.word[11:0];
		end
		bc_rd_q <= bc_mem[k_q[BC_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_waddr] <= val_wdata;
		end
		vd_q <= val_mem[val_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			clr_req_q <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_v_q && res_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VAL_AW'(VAL_DEPTH - 1)) begin
						clr_q     <= '0;
						clr_req_q <= 1'b0;
						state_q   <= clr_req_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						priority if (pop_data.kind == REQ_CLEAR) begin
							clr_req_q <= 1'b1;
							state_q   <= S_CLR;
						end else if (pop_data.kind == REQ_READ &&
							32'(pop_data.addr) < VAL_DEPTH) begin
							state_q <= S_RDW;
						end else if (pop_data.kind == REQ_ADD) begin
							if (pop_data.idx_err) begin
								st_q    <= ST_RANGE;
								state_q <= S_DONE;
							end else if (32'(pop_data.brow) + 1 >= RS_DEPTH) begin
								st_q    <= ST_NOT_FOUND;
								state_q <= S_DONE;
							end else begin
								state_q <= S_PTR;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_PTR: begin
					k_q     <= KW'(rs_a_q);
					end_q   <= (32'(rs_b_q) > MAX_BLOCKS) ? KW'(MAX_BLOCKS) : KW'(rs_b_q);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (k_q < end_q) begin
						state_q <= S_CHK;
					end else begin
						st_q    <= ST_NOT_FOUND;
						state_q <= S_DONE;
					end
				end
				S_CHK: begin
					if (bc_rd_q == cur_q.bcol) begin
						state_q <= S_IDX;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_IDX: begin
					idx_q <= VAL_AW'(k_q[BC_AW-1:0]) * VAL_AW'(cfg.bs2) +
						VAL_AW'(cur_q.roff) * VAL_AW'(cfg.bs) + VAL_AW'(cur_q.coff);
					state_q <= S_VRD;
				end
				S_VRD: begin
					state_q <= S_VWR;
				end
				S_VWR: begin
					state_q <= S_DONE;
				end
				S_RDW: begin
					rd_q    <= vd_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_v_q  <= 1'b1;
						out_st_q <= st_q;
						out_rd_q <= rd_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// fresh request clears the result word
			if (take) begin
				cur_q <= pop_data;
				st_q  <= (pop_data.kind == REQ_ADD && pop_data.idx_err) ? ST_RANGE : ST_OK;
				rd_q  <= '0;
				if (pop_data.kind == REQ_ADD && !pop_data.idx_err &&
					32'(pop_data.brow) + 1 >= RS_DEPTH) begin
					st_q <= ST_NOT_FOUND;
				end
			end
		end
	end

	assign res_ch.valid      = out_v_q;
	assign res_ch.status     = out_st_q;
	assign res_ch.read_value = out_rd_q;
endmodule
